### hdl/qpmm_pkg.sv
// Package for the plus-layout quadrotor motor mixer.
// Types, register codes, reset values and rounding/saturation helpers.
// No dependencies.
package qpmm_pkg;

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned NUM_MOTORS = 4;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [48:0] wide_t;
  typedef logic [30:0]        volt_t;
  typedef logic [1:0]         cfg_idx_t;
  typedef logic [31:0]        cfg_data_t;

  localparam cfg_idx_t REG_HALF_INV_LEVER = 2'd0;
  localparam cfg_idx_t REG_INV_FORCE_PER_V = 2'd1;
  localparam cfg_idx_t REG_INV_TORQUE_PER_V = 2'd2;
  localparam cfg_idx_t REG_TORQUE_GAIN = 2'd3;

  localparam cfg_data_t RST_HALF_INV_LEVER = 32'd119156;
  localparam cfg_data_t RST_INV_FORCE_PER_V = 32'd117036;
  localparam cfg_data_t RST_INV_TORQUE_PER_V = 32'd8206382;
  localparam cfg_data_t RST_TORQUE_GAIN = 32'd34299523;

  typedef struct packed {
    cfg_data_t half_inv_lever;
    cfg_data_t inv_force_per_v;
    cfg_data_t inv_torque_per_v;
    cfg_data_t torque_gain;
  } cfg_regs_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic                  in_ready;
    logic                  out_valid;
  } pipe_ctl_t;

  // signed 32 x unsigned 32, exact
  function automatic logic signed [63:0] mul_su(input q16_t a, input cfg_data_t b);
    logic signed [64:0] m;
    m = a * $signed({1'b0, b});
    return m[63:0];
  endfunction

  // round half up, drop 16 fraction bits
  function automatic wide_t rnd16(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = {p[63], p} + 65'sd32768;
    return t[64:16];
  endfunction

  function automatic q16_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

### hdl/qpmm_if.sv
// Valid/ready channels for wrench words in and mixer words out.
// Depends on qpmm_pkg.
interface qpmm_in_if;
  import qpmm_pkg::*;
  logic valid;
  logic ready;
  q16_t thrust_z;
  q16_t roll_torque;
  q16_t pitch_torque;
  q16_t yaw_torque;
  modport source (output valid, thrust_z, roll_torque, pitch_torque, yaw_torque,
                  input ready);
  modport sink (input valid, thrust_z, roll_torque, pitch_torque, yaw_torque,
                output ready);
endinterface

interface qpmm_out_if;
  import qpmm_pkg::*;
  logic  valid;
  logic  ready;
  volt_t volt_front;
  volt_t volt_left;
  volt_t volt_back;
  volt_t volt_right;
  q16_t  force_front;
  q16_t  force_left;
  q16_t  force_back;
  q16_t  force_right;
  q16_t  spin_front;
  q16_t  spin_left;
  q16_t  spin_back;
  q16_t  spin_right;
  modport source (output valid, volt_front, volt_left, volt_back, volt_right,
                  force_front, force_left, force_back, force_right,
                  spin_front, spin_left, spin_back, spin_right, input ready);
  modport sink (input valid, volt_front, volt_left, volt_back, volt_right,
                force_front, force_left, force_back, force_right,
                spin_front, spin_left, spin_back, spin_right, output ready);
endinterface

### hdl/qpmm_cfg.sv
// Configuration register file of the motor mixer.
// Depends on qpmm_pkg.
module qpmm_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  qpmm_pkg::cfg_idx_t  cfg_idx,
  input  qpmm_pkg::cfg_data_t cfg_data,
  output qpmm_pkg::cfg_regs_t regs
);
  import qpmm_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_HALF_INV_LEVER:   regs_nxt.half_inv_lever = cfg_data;
        REG_INV_FORCE_PER_V:  regs_nxt.inv_force_per_v = cfg_data;
        REG_INV_TORQUE_PER_V: regs_nxt.inv_torque_per_v = cfg_data;
        REG_TORQUE_GAIN:      regs_nxt.torque_gain = cfg_data;
        default:              regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.half_inv_lever <= RST_HALF_INV_LEVER;
      regs_r.inv_force_per_v <= RST_INV_FORCE_PER_V;
      regs_r.inv_torque_per_v <= RST_INV_TORQUE_PER_V;
      regs_r.torque_gain <= RST_TORQUE_GAIN;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;
endmodule

### hdl/qpmm_ctrl.sv
// Pipeline valid bits and per-stage load enables with ready backpressure.
// Depends on qpmm_pkg.
module qpmm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output qpmm_pkg::pipe_ctl_t ctl
);
  import qpmm_pkg::*;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] ready;

  always_comb begin
    ready[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ready[0]) valid_nxt[0] = in_valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ready[k]) valid_nxt[k] = valid_r[k-1];
    end
    if (!ready[NUM_STAGES-1] && out_ready) valid_nxt[NUM_STAGES-1] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load = ready;
  assign ctl.in_ready = ready[0];
  assign ctl.out_valid = valid_r[NUM_STAGES-1];
endmodule

### hdl/qpmm_force.sv
// Front end: arm products, thrust quarter, yaw voltage term and saturated motor forces.
// Uses pipeline stages 0 and 1. Depends on qpmm_pkg.
module qpmm_force (
  input  logic                clk,
  input  qpmm_pkg::pipe_ctl_t ctl,
  input  qpmm_pkg::cfg_regs_t regs,
  input  qpmm_pkg::q16_t      thrust_z,
  input  qpmm_pkg::q16_t      roll_torque,
  input  qpmm_pkg::q16_t      pitch_torque,
  input  qpmm_pkg::q16_t      yaw_torque,
  output qpmm_pkg::q16_t      motor_force [qpmm_pkg::NUM_MOTORS],
  output qpmm_pkg::wide_t     yaw_term,
  output logic                zero
);
  import qpmm_pkg::*;

  logic signed [63:0] pitch_p_r;
  logic signed [63:0] roll_p_r;
  logic signed [63:0] yaw_p_r;
  logic signed [30:0] quarter_r;
  logic               zero1_r;
  logic signed [32:0] quarter_sum;

  q16_t  force_r [NUM_MOTORS];
  wide_t yaw_r;
  logic  zero2_r;

  wide_t              ph;
  wide_t              rh;
  logic signed [64:0] yaw_sum;
  logic signed [63:0] q64;

  assign quarter_sum = {thrust_z[31], thrust_z} + 33'sd2;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      pitch_p_r <= mul_su(pitch_torque, regs.half_inv_lever);
      roll_p_r <= mul_su(roll_torque, regs.half_inv_lever);
      yaw_p_r <= mul_su(yaw_torque, regs.inv_torque_per_v);
      quarter_r <= quarter_sum[32:2];
      zero1_r <= (thrust_z <= 32'sd0);
    end
  end

  always_comb begin
    ph = rnd16(pitch_p_r);
    rh = rnd16(roll_p_r);
    yaw_sum = {yaw_p_r[63], yaw_p_r} + 65'sd131072;
    q64 = 64'(quarter_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      force_r[0] <= sat32(q64 - 64'(ph));
      force_r[1] <= sat32(q64 - 64'(rh));
      force_r[2] <= sat32(q64 + 64'(ph));
      force_r[3] <= sat32(q64 + 64'(rh));
      yaw_r <= wide_t'($signed(yaw_sum[64:18]));
      zero2_r <= zero1_r;
    end
  end

  assign motor_force = force_r;
  assign yaw_term = yaw_r;
  assign zero = zero2_r;
endmodule

### hdl/qpmm_lane.sv
// One motor lane: voltage product, yaw mix, spin product and output clamp.
// Uses pipeline stages 2 to 5. Depends on qpmm_pkg.
module qpmm_lane (
  input  logic                clk,
  input  qpmm_pkg::pipe_ctl_t ctl,
  input  qpmm_pkg::cfg_regs_t regs,
  input  logic                yaw_neg,
  input  qpmm_pkg::q16_t      force_in,
  input  qpmm_pkg::wide_t     yaw_term,
  input  logic                zero,
  output qpmm_pkg::volt_t     volt,
  output qpmm_pkg::q16_t      force_out,
  output qpmm_pkg::q16_t      spin
);
  import qpmm_pkg::*;

  logic signed [63:0] fprod_r;
  q16_t               f2_r;
  wide_t              yt2_r;
  logic               z2_r;

  q16_t               v3_r;
  q16_t               f3_r;
  logic               z3_r;

  logic signed [63:0] sprod_r;
  q16_t               v4_r;
  q16_t               f4_r;
  logic               z4_r;

  volt_t              volt_r;
  q16_t               force_r;
  q16_t               spin_r;

  logic signed [63:0] fv64;
  logic signed [63:0] yt64;
  logic signed [64:0] spin_sum;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      fprod_r <= mul_su(force_in, regs.inv_force_per_v);
      f2_r <= force_in;
      yt2_r <= yaw_term;
      z2_r <= zero;
    end
  end

  always_comb begin
    fv64 = 64'(rnd16(fprod_r));
    yt64 = 64'(yt2_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      v3_r <= yaw_neg ? sat32(fv64 - yt64) : sat32(fv64 + yt64);
      f3_r <= f2_r;
      z3_r <= z2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      sprod_r <= mul_su(v3_r, regs.torque_gain);
      v4_r <= v3_r;
      f4_r <= f3_r;
      z4_r <= z3_r;
    end
  end

  assign spin_sum = {sprod_r[63], sprod_r} + 65'sd2147483648;

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      if (z4_r) begin
        volt_r <= '0;
        force_r <= '0;
        spin_r <= '0;
      end else begin
        volt_r <= (v4_r > 32'sd0) ? v4_r[30:0] : '0;
        force_r <= f4_r;
        spin_r <= sat32(64'($signed(spin_sum[64:32])));
      end
    end
  end

  assign volt = volt_r;
  assign force_out = force_r;
  assign spin = spin_r;
endmodule

### hdl/quadrotor_plus_motor_mixer_core.sv
// Plus-layout quadrotor motor mixer. Each wrench word (thrust, roll, pitch,
// yaw, signed Q15.16) becomes one word of four motor voltages, forces and
// spin torques. The datapath is a six-stage pipeline: one word enters per
// cycle unless backpressure has filled the pipeline; it is built from the
// three chained 32x32 multiplies (arm, voltage, spin) each with a rounding
// and saturation stage behind it. Backpressure stalls only the stages that
// are full. Write configuration registers only while no word is in flight.
// Depends on qpmm_pkg, qpmm_if, qpmm_cfg, qpmm_ctrl, qpmm_force, qpmm_lane.
module quadrotor_plus_motor_mixer_core (
  input  logic                clk,
  input  logic                rst_n,
  qpmm_in_if.sink             in_wrench,
  qpmm_out_if.source          out_mix,
  input  logic                cfg_we,
  input  qpmm_pkg::cfg_idx_t  cfg_idx,
  input  qpmm_pkg::cfg_data_t cfg_data
);
  import qpmm_pkg::*;

  cfg_regs_t regs;
  pipe_ctl_t ctl;
  q16_t      motor_force [NUM_MOTORS];
  wide_t     yaw_term;
  logic      zero;
  volt_t     lane_volt [NUM_MOTORS];
  q16_t      lane_force [NUM_MOTORS];
  q16_t      lane_spin [NUM_MOTORS];

  qpmm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .regs     (regs)
  );

  qpmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_wrench.valid),
    .out_ready (out_mix.ready),
    .ctl       (ctl)
  );

  qpmm_force u_force (
    .clk          (clk),
    .ctl          (ctl),
    .regs         (regs),
    .thrust_z     (in_wrench.thrust_z),
    .roll_torque  (in_wrench.roll_torque),
    .pitch_torque (in_wrench.pitch_torque),
    .yaw_torque   (in_wrench.yaw_torque),
    .motor_force  (motor_force),
    .yaw_term     (yaw_term),
    .zero         (zero)
  );

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
    qpmm_lane u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .regs      (regs),
      .yaw_neg   (1'(m % 2)),
      .force_in  (motor_force[m]),
      .yaw_term  (yaw_term),
      .zero      (zero),
      .volt      (lane_volt[m]),
      .force_out (lane_force[m]),
      .spin      (lane_spin[m])
    );
  end

  assign in_wrench.ready = ctl.in_ready;
  assign out_mix.valid = ctl.out_valid;

  assign out_mix.volt_front = lane_volt[0];
  assign out_mix.volt_left = lane_volt[1];
  assign out_mix.volt_back = lane_volt[2];
  assign out_mix.volt_right = lane_volt[3];
  assign out_mix.force_front = lane_force[0];
  assign out_mix.force_left = lane_force[1];
  assign out_mix.force_back = lane_force[2];
  assign out_mix.force_right = lane_force[3];
  assign out_mix.spin_front = lane_spin[0];
  assign out_mix.spin_left = lane_spin[1];
  assign out_mix.spin_back = lane_spin[2];
  assign out_mix.spin_right = lane_spin[3];
endmodule

### bench/qpmm_mix_checker.sv
// Checker for the plus-layout motor mixer: tracks register writes, predicts
// every mixer word from each accepted wrench word and compares in order.
// Depends on qpmm_pkg and qpmm_if.
module qpmm_mix_checker
  import qpmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qpmm_in_if        in_ch,
  qpmm_out_if       out_ch,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_idx,
  input  cfg_data_t cfg_data,
  output int        mismatches,
  output int        pending
);

  typedef struct packed {
    volt_t [3:0] volt;
    q16_t  [3:0] force_n;
    q16_t  [3:0] spin;
  } mix_word_t;

  cfg_data_t arm_gain;
  cfg_data_t volt_per_force;
  cfg_data_t volt_per_torque;
  cfg_data_t spin_gain;
  mix_word_t mix_expected_q[$];
  string     motor_name[4] = '{"front", "left", "back", "right"};

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic longint mul_wide(input q16_t a, input cfg_data_t b);
    longint la;
    longint lb;
    la = a;
    lb = b;
    return la * lb;
  endfunction

  // floor((x + 2^(s-1)) / 2^s)
  function automatic longint round_shift(input longint x, input int s);
    logic signed [64:0] t;
    t = {x[63], x};
    t = t + (65'sd1 <<< (s - 1));
    return longint'(t >>> s);
  endfunction

  function automatic q16_t clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic mix_word_t mix_wrench(input q16_t thr, input q16_t rol,
                                           input q16_t pit, input q16_t yaw);
    mix_word_t w;
    longint    quarter;
    longint    pitch_arm;
    longint    roll_arm;
    longint    yaw_volt;
    longint    fv;
    q16_t      v;
    q16_t      f[4];
    int        k;
    w = '0;
    if (thr <= 0) return w;
    quarter = round_shift(thr, 2);
    pitch_arm = round_shift(mul_wide(pit, arm_gain), 16);
    roll_arm = round_shift(mul_wide(rol, arm_gain), 16);
    yaw_volt = round_shift(mul_wide(yaw, volt_per_torque), 18);
    f[0] = clamp32(quarter - pitch_arm);
    f[1] = clamp32(quarter - roll_arm);
    f[2] = clamp32(quarter + pitch_arm);
    f[3] = clamp32(quarter + roll_arm);
    for (k = 0; k < 4; k++) begin
      fv = round_shift(mul_wide(f[k], volt_per_force), 16);
      v = clamp32((k % 2 == 1) ? fv - yaw_volt : fv + yaw_volt);
      w.spin[k] = clamp32(round_shift(mul_wide(v, spin_gain), 32));
      w.volt[k] = (v > 0) ? v[30:0] : '0;
      w.force_n[k] = f[k];
    end
    return w;
  endfunction

  task automatic note_mismatch(input string field, input int k,
                               input logic [31:0] want, input logic [31:0] seen);
    $display("%0t: %s_%s expected %h got %h", $time, field, motor_name[k], want, seen);
    mismatches++;
  endtask

  always @(posedge clk) begin
    mix_word_t got;
    mix_word_t want;
    int        k;
    if (!rst_n) begin
      arm_gain = RST_HALF_INV_LEVER;
      volt_per_force = RST_INV_FORCE_PER_V;
      volt_per_torque = RST_INV_TORQUE_PER_V;
      spin_gain = RST_TORQUE_GAIN;
      mix_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_HALF_INV_LEVER:   arm_gain = cfg_data;
          REG_INV_FORCE_PER_V:  volt_per_force = cfg_data;
          REG_INV_TORQUE_PER_V: volt_per_torque = cfg_data;
          REG_TORQUE_GAIN:      spin_gain = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.volt = {out_ch.volt_right, out_ch.volt_back, out_ch.volt_left,
                    out_ch.volt_front};
        got.force_n = {out_ch.force_right, out_ch.force_back, out_ch.force_left,
                       out_ch.force_front};
        got.spin = {out_ch.spin_right, out_ch.spin_back, out_ch.spin_left,
                    out_ch.spin_front};
        if (mix_expected_q.size() == 0) begin
          $display("%0t: mixer word with no wrench word pending", $time);
          mismatches++;
        end else begin
          want = mix_expected_q.pop_front();
          for (k = 0; k < 4; k++) begin
            if (got.volt[k] !== want.volt[k])
              note_mismatch("volt", k, want.volt[k], got.volt[k]);
            if (got.force_n[k] !== want.force_n[k])
              note_mismatch("force", k, want.force_n[k], got.force_n[k]);
            if (got.spin[k] !== want.spin[k])
              note_mismatch("spin", k, want.spin[k], got.spin[k]);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        mix_expected_q.push_back(mix_wrench(in_ch.thrust_z, in_ch.roll_torque,
                                            in_ch.pitch_torque, in_ch.yaw_torque));
    end
    pending <= mix_expected_q.size();
  end

endmodule

### bench/testbench.sv
// Top of the motor mixer bench: clock, reset, register phases, wrench
// stimulus with bursts and stalls, and the verdict.
// Depends on qpmm_pkg, qpmm_if, qpmm_mix_checker and the mixer core.
module testbench;
  import qpmm_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;
  int        mismatches;
  int        pending;
  bit        hold_req = 1'b0;

  qpmm_in_if  wrench_ch();
  qpmm_out_if mix_ch();

  quadrotor_plus_motor_mixer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_wrench (wrench_ch),
    .out_mix   (mix_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  qpmm_mix_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (wrench_ch),
    .out_ch     (mix_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  localparam q16_t HOVER = 32'sd642908;
  localparam q16_t QMAX = 32'sh7fffffff;
  localparam q16_t QMIN = 32'sh80000000;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #800000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stall styles, plus one long hold on request
  initial begin
    int style;
    int span;
    int hold_left;
    style = 0;
    span = 0;
    hold_left = 0;
    mix_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        mix_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        mix_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span = $urandom_range(20, 120);
        end
        span--;
        case (style)
          0: mix_ch.ready <= 1'b1;
          1: mix_ch.ready <= $urandom_range(0, 1);
          2: mix_ch.ready <= ($urandom_range(0, 3) == 0);
          default: mix_ch.ready <= (span % 3 != 0);
        endcase
      end
    end
  end

  function automatic q16_t rand_q16();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return '0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic cfg_data_t rand_reg(input cfg_data_t nominal);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(nominal / 2, nominal * 2);
    endcase
  endfunction

  task automatic send_word(input q16_t thr, input q16_t rol, input q16_t pit,
                           input q16_t yaw);
    wrench_ch.valid <= 1'b1;
    wrench_ch.thrust_z <= thr;
    wrench_ch.roll_torque <= rol;
    wrench_ch.pitch_torque <= pit;
    wrench_ch.yaw_torque <= yaw;
    do @(posedge clk); while (!wrench_ch.ready);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    wrench_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input cfg_data_t lever, input cfg_data_t fpv,
                           input cfg_data_t tpv, input cfg_data_t gain);
    write_reg(REG_HALF_INV_LEVER, lever);
    write_reg(REG_INV_FORCE_PER_V, fpv);
    write_reg(REG_INV_TORQUE_PER_V, tpv);
    write_reg(REG_TORQUE_GAIN, gain);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int   phase;
    int   n;
    int   flood;
    int   burst_left;
    int   gap;
    q16_t thr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_HALF_INV_LEVER;
    cfg_data = '0;
    wrench_ch.valid = 1'b0;
    wrench_ch.thrust_z = '0;
    wrench_ch.roll_torque = '0;
    wrench_ch.pitch_torque = '0;
    wrench_ch.yaw_torque = '0;
    flood = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset register values
    send_word('0, '0, '0, '0);
    send_word('0, QMAX, QMIN, QMAX);
    send_word(-32'sd65536, 32'sd1000, 32'sd1000, 32'sd1000);
    send_word(QMIN, QMAX, QMAX, QMAX);
    send_word(32'sd1, '0, '0, '0);
    send_word(32'sd2, '0, '0, '0);
    send_word(HOVER, '0, '0, '0);
    send_word(HOVER, 32'sd32768, '0, '0);
    send_word(HOVER, '0, -32'sd32768, '0);
    send_word(HOVER, '0, '0, 32'sd65536);
    send_word(HOVER, '0, '0, -32'sd65536);
    send_word(HOVER, '0, '0, QMAX);
    send_word(HOVER, '0, '0, QMIN);
    send_word(QMAX, '0, '0, '0);
    send_word(QMAX, QMIN, QMIN, QMIN);
    send_word(QMAX, QMAX, QMAX, QMAX);
    send_word(32'sd65536, QMAX, QMIN, '0);
    send_word(HOVER, -32'sd1, -32'sd1, -32'sd1);

    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      case (phase)
        0: load_regs('0, '0, '0, '0);
        1: load_regs('1, '1, '1, '1);
        2: load_regs(RST_HALF_INV_LEVER, RST_INV_FORCE_PER_V, RST_INV_TORQUE_PER_V,
                     RST_TORQUE_GAIN);
        default: load_regs(rand_reg(RST_HALF_INV_LEVER), rand_reg(RST_INV_FORCE_PER_V),
                           rand_reg(RST_INV_TORQUE_PER_V), rand_reg(RST_TORQUE_GAIN));
      endcase
      if (phase == 3) begin
        hold_req = 1'b1;
        flood = 60;
      end
      for (n = 0; n < 115; n++) begin
        if (phase == 6 && n == 57) wait_idle();
        if (flood > 0) begin
          flood--;
        end else begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 3);
            if (gap > 0) begin
              wrench_ch.valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
          burst_left--;
        end
        thr = rand_q16();
        if ($urandom_range(0, 3) != 0) thr[31] = 1'b0;
        send_word(thr, rand_q16(), rand_q16(), rand_q16());
      end
    end

    wait_idle();
    if (pending != 0) $display("%0t: %0d mixer words never arrived", $time, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
